[rtl/mcgs_pkg.sv]
package mcgs_pkg;

   // Field widths fixed by the item format
   localparam int ROW_W   = 10;
   localparam int COL_W   = 16;
   localparam int QRY_W   = 16;
   localparam int PROD_W  = COL_W + QRY_W;
   localparam int SCORE_W = 48;

   // Width used to compare a row against the ROWS parameter (up to 65536)
   localparam int ROW_CMP_W = 17;

   // Configuration port
   localparam int CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCORE_INIT  = 1'b0,
      CSR_MASK_ENABLE = 1'b1
   } csr_index_type;

   typedef logic signed [SCORE_W-1:0] score_type;
   typedef logic signed [PROD_W-1:0]  prod_type;

   localparam score_type SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
   localparam score_type SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

   // Per-item flags carried alongside the multiply stage
   typedef struct packed {
      logic first_column;
      logic last_column;
      logic candidate;
   } item_ctl_type;

endpackage

[rtl/mcgs_score_mem.sv]
module mcgs_score_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   output mcgs_pkg::score_type          rd_data,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  mcgs_pkg::score_type          wr_data
);

   mcgs_pkg::score_type mem [DEPTH];
   mcgs_pkg::score_type rd_data_ff;

   // Single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, old data on a same-cycle write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mcgs_accum.sv]
module mcgs_accum (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [mcgs_pkg::ROW_W-1:0]          row,
   input  logic                                first_column,
   input  mcgs_pkg::prod_type                  product,
   input  mcgs_pkg::score_type                 mem_score,
   input  mcgs_pkg::score_type                 score_init,
   input  logic                                write_back,
   output mcgs_pkg::score_type                 acc
);

   // Last score written back; covers a read issued in the same cycle as the write
   logic                              fwd_valid_ff;
   logic                              fwd_valid_in;
   logic [mcgs_pkg::ROW_W-1:0]        fwd_row_ff;
   mcgs_pkg::score_type               fwd_score_ff;

   mcgs_pkg::score_type               base;
   logic signed [mcgs_pkg::SCORE_W:0] sum;

   // Base select: bias, forwarded score or memory
   always_comb begin
      if (first_column) begin
         base = score_init;
      end else if (fwd_valid_ff && (fwd_row_ff == row)) begin
         base = fwd_score_ff;
      end else begin
         base = mem_score;
      end
   end

   // Saturating add
   always_comb begin
      sum = {base[mcgs_pkg::SCORE_W-1], base} + (mcgs_pkg::SCORE_W+1)'(product);
      if (sum[mcgs_pkg::SCORE_W] != sum[mcgs_pkg::SCORE_W-1]) begin
         acc = sum[mcgs_pkg::SCORE_W] ? mcgs_pkg::SCORE_MIN : mcgs_pkg::SCORE_MAX;
      end else begin
         acc = sum[mcgs_pkg::SCORE_W-1:0];
      end
   end

   assign fwd_valid_in = fwd_valid_ff | write_back;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_back) begin
         fwd_row_ff   <= row;
         fwd_score_ff <= acc;
      end
   end

endmodule

[rtl/masked_columnar_gemv_scorer_top.sv]
// Streaming masked matrix-vector scorer. One matrix element is taken per
// cycle while the result port does not stall. Acceptance forms the 16x16
// product and reads the row's running score from the score memory (one read
// and one write port, registered read) into the multiply/read stage; from
// there the score is added, saturated to 48 bits and written back, and the
// result register is loaded, forwarding the last written score so consecutive
// elements of the same row chain without a bubble. Only last-column elements
// give a result; rows at or above ROWS are dropped. A stalled result port
// holds the pipe once the result register and the element in flight are both
// waiting. Score entries are undefined until a first-column element writes
// them; there is no clearing pass. Configuration writes are always ready.
module masked_columnar_gemv_scorer_top #(
   parameter int ROWS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mcgs_pkg::ROW_W-1:0]          req_row_index,
   input  logic signed [mcgs_pkg::COL_W-1:0]   req_column_value,
   input  logic signed [mcgs_pkg::QRY_W-1:0]   req_query_value,
   input  logic                                req_candidate,
   input  logic                                req_first_column,
   input  logic                                req_last_column,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mcgs_pkg::ROW_W-1:0]          rsp_out_row,
   output logic signed [mcgs_pkg::SCORE_W-1:0] rsp_score,
   output logic                                rsp_excluded,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mcgs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mcgs_pkg::SCORE_W-1:0]        csr_data
);

   localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;

   // Configuration registers
   mcgs_pkg::score_type score_init_ff;
   logic                mask_enable_ff;

   // Multiply / read stage
   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   logic [mcgs_pkg::ROW_W-1:0] s1_row_ff;
   mcgs_pkg::prod_type         s1_prod_ff;
   mcgs_pkg::item_ctl_type     s1_ctl_ff;

   // Result register
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [mcgs_pkg::ROW_W-1:0] rsp_row_ff;
   mcgs_pkg::score_type        rsp_score_ff;
   logic                       rsp_excluded_ff;

   logic                       req_fire;
   logic                       row_in_range;
   logic                       rsp_free;
   logic                       s1_advance;
   logic                       s1_emit;
   logic [AW-1:0]              rd_addr;
   logic [AW-1:0]              wr_addr;
   mcgs_pkg::score_type        mem_score;
   mcgs_pkg::score_type        acc;

   // Config writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         score_init_ff  <= '0;
         mask_enable_ff <= 1'b0;
      end else if (csr_valid) begin
         case (mcgs_pkg::csr_index_type'(csr_index))
            mcgs_pkg::CSR_SCORE_INIT:  score_init_ff  <= csr_data;
            mcgs_pkg::CSR_MASK_ENABLE: mask_enable_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Handshake and pipe control
   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign s1_emit      = s1_ctl_ff.last_column;
   assign s1_advance   = s1_valid_ff && (!s1_emit || rsp_free);
   assign req_ready    = !s1_valid_ff || s1_advance;
   assign req_fire     = req_valid && req_ready;
   assign row_in_range = {{(mcgs_pkg::ROW_CMP_W-mcgs_pkg::ROW_W){1'b0}}, req_row_index}
                         < mcgs_pkg::ROW_CMP_W'(ROWS);

   assign s1_valid_in  = (req_fire && row_in_range) || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = (s1_advance && s1_emit) || (rsp_valid_ff && !rsp_ready);

   assign rd_addr = AW'({{(mcgs_pkg::ROW_CMP_W-mcgs_pkg::ROW_W){1'b0}}, req_row_index});
   assign wr_addr = AW'({{(mcgs_pkg::ROW_CMP_W-mcgs_pkg::ROW_W){1'b0}}, s1_row_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Stage 1 payload: product and flags
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_row_ff              <= req_row_index;
         s1_prod_ff             <= req_column_value * req_query_value;
         s1_ctl_ff.first_column <= req_first_column;
         s1_ctl_ff.last_column  <= req_last_column;
         s1_ctl_ff.candidate    <= req_candidate;
      end
   end

   mcgs_score_mem #(
      .DEPTH (ROWS),
      .AW    (AW)
   ) u_score_mem (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (mem_score),
      .wr_en   (s1_advance),
      .wr_addr (wr_addr),
      .wr_data (acc)
   );

   mcgs_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .row          (s1_row_ff),
      .first_column (s1_ctl_ff.first_column),
      .product      (s1_prod_ff),
      .mem_score    (mem_score),
      .score_init   (score_init_ff),
      .write_back   (s1_advance),
      .acc          (acc)
   );

   // Result register with masking
   always_ff @(posedge clock) begin
      if (s1_advance && s1_emit) begin
         rsp_row_ff <= s1_row_ff;
         if (mask_enable_ff && !s1_ctl_ff.candidate) begin
            rsp_score_ff    <= mcgs_pkg::SCORE_MIN;
            rsp_excluded_ff <= 1'b1;
         end else begin
            rsp_score_ff    <= acc;
            rsp_excluded_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_row  = rsp_row_ff;
   assign rsp_score    = rsp_score_ff;
   assign rsp_excluded = rsp_excluded_ff;

endmodule
